### design/sct_pkg.sv
package sct_pkg;

  // Fixed-point format of angles and results.
  localparam int FRAC_BITS = 16;
  localparam int ANGLE_W   = 32;
  localparam int OUT_W     = 18;
  localparam int OUT_MAX   = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN   = -(2 ** (OUT_W - 1));

  // Series structure: one cell per term after the first, sine and cosine lanes.
  localparam int N_CELLS  = 4;
  localparam int CELL_W   = $clog2(N_CELLS);
  localparam int N_LANES  = 2;
  localparam int LANE_SIN = 0;
  localparam int LANE_COS = 1;

  // Range reduction constants: 1/(2pi) with 32 fraction bits, 2pi with 40.
  localparam int INV_W       = 32;
  localparam int INV_FRAC    = 32;
  localparam logic signed [INV_W-1:0] INV_TWO_PI = 32'sh28BE60DC;
  localparam int TWO_PI_W    = 44;
  localparam int TWO_PI_FRAC = 40;
  localparam logic signed [TWO_PI_W-1:0] TWO_PI = 44'sh6487ED5110B;

  // Reduction datapath widths.
  localparam int P1_W        = ANGLE_W + INV_W;
  localparam int ROUND_SHIFT = FRAC_BITS + INV_FRAC;
  localparam int N_W         = P1_W - ROUND_SHIFT;
  localparam int NP_W        = N_W + TWO_PI_W;
  localparam int RED_SHIFT   = TWO_PI_FRAC - FRAC_BITS;
  localparam int R_W         = FRAC_BITS + 3;
  // The reduced angle is small, so the subtraction only needs these low bits.
  localparam int D_W         = RED_SHIFT + R_W;

  // Series datapath widths.
  localparam int X_W  = FRAC_BITS + 5;
  localparam int T_W  = FRAC_BITS + 4;
  localparam int S_W  = FRAC_BITS + 5;
  localparam int P_W  = T_W + X_W;
  localparam int Q_W  = FRAC_BITS + 9;
  localparam int U_W  = Q_W + 6;
  localparam int K_W  = 7;
  localparam int EXT_W = S_W + OUT_W;

  // Term divisors, per lane and cell.
  localparam int unsigned K_DIV [N_LANES][N_CELLS] = '{
    '{6, 20, 42, 72},
    '{2, 12, 30, 56}
  };

  // Truncated reciprocals floor(2^U_W / k) for the divide-by-constant.
  localparam longint unsigned RECIP_ONE = 64'd1 << U_W;
  localparam logic [U_W-1:0] K_RECIP [N_LANES][N_CELLS] = '{
    '{U_W'(RECIP_ONE / 6), U_W'(RECIP_ONE / 20), U_W'(RECIP_ONE / 42),
      U_W'(RECIP_ONE / 72)},
    '{U_W'(RECIP_ONE / 2), U_W'(RECIP_ONE / 12), U_W'(RECIP_ONE / 30),
      U_W'(RECIP_ONE / 56)}
  };

  // Pipeline depth: reduction stages, cell stages and the output register.
  localparam int RED_STAGES  = 5;
  localparam int CELL_STAGES = 5;
  localparam int PIPE_DEPTH  = RED_STAGES + N_CELLS * CELL_STAGES + 1;

  // Data handed from cell to cell.
  typedef struct packed {
    logic signed [T_W-1:0] sin_term;
    logic signed [T_W-1:0] cos_term;
    logic signed [S_W-1:0] sin_sum;
    logic signed [S_W-1:0] cos_sum;
    logic signed [X_W-1:0] x2;
  } chain_t;

  // Clamp a series sum to the output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [S_W-1:0] v);
    logic signed [EXT_W-1:0] w;
    logic signed [EXT_W-1:0] res;
    w = EXT_W'(v);
    if (w > EXT_W'(OUT_MAX)) begin
      res = EXT_W'(OUT_MAX);
    end else if (w < EXT_W'(OUT_MIN)) begin
      res = EXT_W'(OUT_MIN);
    end else begin
      res = w;
    end
    return res[OUT_W-1:0];
  endfunction

endpackage

### design/sct_channels_if.sv
// Angle request channel.
interface sct_angle_if import sct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// Sine and cosine result channel.
interface sct_result_if import sct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine_value;
  logic signed [OUT_W-1:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

### design/sct_reduce.sv
module sct_reduce import sct_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ANGLE_W-1:0] in_angle_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output chain_t                    out_chain_o
);

  localparam logic signed [P1_W-1:0] ROUND_HALF = P1_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [T_W-1:0]  ONE_T      = T_W'(1) << FRAC_BITS;
  localparam logic signed [S_W-1:0]  ONE_S      = S_W'(1) << FRAC_BITS;

  logic [RED_STAGES-1:0] v_q;
  logic [RED_STAGES-1:0] v_src;
  logic [RED_STAGES:0]   en;

  logic signed [ANGLE_W-1:0] angle0_q, angle1_q, angle2_q;
  logic signed [P1_W-1:0]    p1_q;
  logic signed [N_W-1:0]     n_q;
  logic [D_W-1:0]            np_q;
  logic signed [R_W-1:0]     r3_q, r4_q;
  logic signed [X_W-1:0]     x2_q;

  logic signed [P1_W-1:0]    p1_d;
  logic signed [P1_W-1:0]    rnd_sum;
  logic signed [NP_W-1:0]    np_full;
  logic [D_W-1:0]            diff;
  logic signed [2*R_W-1:0]   sq;

  // A stage may load when it is empty or its successor loads.
  always_comb begin
    en[RED_STAGES] = out_ready_i;
    for (int s = RED_STAGES - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign v_src      = {v_q[RED_STAGES-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < RED_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_src[s];
        end
      end
    end
  end

  // Datapath: turn count by reciprocal, subtract whole turns, square.
  assign p1_d    = in_angle_i * INV_TWO_PI;
  assign rnd_sum = p1_q + ROUND_HALF;
  assign np_full = n_q * TWO_PI;
  assign diff    = (D_W'(angle2_q) << RED_SHIFT) - np_q;
  assign sq      = r3_q * r3_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      angle0_q <= in_angle_i;
      p1_q     <= p1_d;
    end
    if (en[1]) begin
      angle1_q <= angle0_q;
      n_q      <= rnd_sum[P1_W-1:ROUND_SHIFT];
    end
    if (en[2]) begin
      angle2_q <= angle1_q;
      np_q     <= np_full[D_W-1:0];
    end
    if (en[3]) begin
      r3_q <= diff[D_W-1:RED_SHIFT];
    end
    if (en[4]) begin
      r4_q <= r3_q;
      x2_q <= sq[FRAC_BITS +: X_W];
    end
  end

  // First terms of both series.
  always_comb begin
    out_chain_o.sin_term = T_W'(r4_q);
    out_chain_o.sin_sum  = S_W'(r4_q);
    out_chain_o.cos_term = ONE_T;
    out_chain_o.cos_sum  = ONE_S;
    out_chain_o.x2       = x2_q;
  end

  assign out_valid_o = v_q[RED_STAGES-1];

endmodule

### design/sct_cell.sv
module sct_cell import sct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CELL_W-1:0] cell_idx_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  chain_t            in_chain_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output chain_t            out_chain_o
);

  logic [CELL_STAGES-1:0] v_q;
  logic [CELL_STAGES-1:0] v_src;
  logic [CELL_STAGES:0]   en;

  logic [K_W-1:0]        k     [N_LANES];
  logic [U_W-1:0]        recip [N_LANES];
  logic [U_W-1:0]        koff  [N_LANES];
  logic signed [T_W-1:0] term_in [N_LANES];
  logic signed [S_W-1:0] sum_in  [N_LANES];

  logic signed [P_W-1:0] prod_q [N_LANES];
  logic [U_W-1:0]        u1_q   [N_LANES];
  logic [U_W-1:0]        u2_q   [N_LANES];
  logic [U_W-1:0]        est_q  [N_LANES];
  logic signed [T_W-1:0] t3_q   [N_LANES];
  logic signed [T_W-1:0] t4_q   [N_LANES];
  logic signed [S_W-1:0] sum0_q [N_LANES];
  logic signed [S_W-1:0] sum1_q [N_LANES];
  logic signed [S_W-1:0] sum2_q [N_LANES];
  logic signed [S_W-1:0] sum3_q [N_LANES];
  logic signed [S_W-1:0] sum4_q [N_LANES];
  logic signed [X_W-1:0] x2_q   [CELL_STAGES];

  logic signed [P_W:0]     neg   [N_LANES];
  logic signed [Q_W-1:0]   q     [N_LANES];
  logic [U_W-1:0]          u_d   [N_LANES];
  logic [2*U_W-1:0]        m     [N_LANES];
  logic [U_W-1:0]          rem   [N_LANES];
  logic [U_W-1:0]          fix   [N_LANES];

  // Divisor and reciprocal of this cell for each lane.
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      k[l]     = K_W'(K_DIV[l][cell_idx_i]);
      recip[l] = K_RECIP[l][cell_idx_i];
      koff[l]  = U_W'(k[l]) << (Q_W - 1);
    end
  end

  always_comb begin
    term_in[LANE_SIN] = in_chain_i.sin_term;
    term_in[LANE_COS] = in_chain_i.cos_term;
    sum_in[LANE_SIN]  = in_chain_i.sin_sum;
    sum_in[LANE_COS]  = in_chain_i.cos_sum;
  end

  // Handshake: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[CELL_STAGES] = out_ready_i;
    for (int s = CELL_STAGES - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign v_src      = {v_q[CELL_STAGES-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < CELL_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_src[s];
        end
      end
    end
  end

  // Floor division of -(term * x2) by k * 2^FRAC_BITS. The quotient is
  // offset by k * 2^(Q_W-1) so the divide-by-constant runs on an unsigned
  // value; the offset drops out of the low bits of the result.
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      neg[l] = -((P_W + 1)'(prod_q[l]));
      q[l]   = neg[l][FRAC_BITS +: Q_W];
      u_d[l] = U_W'(q[l]) + koff[l];
      m[l]   = u1_q[l] * recip[l];
      rem[l] = u2_q[l] - U_W'(est_q[l] * U_W'(k[l]));
      fix[l] = (rem[l] >= U_W'(k[l])) ? est_q[l] + U_W'(1) : est_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x2_q[0] <= in_chain_i.x2;
    end
    for (int s = 1; s < CELL_STAGES; s++) begin
      if (en[s]) begin
        x2_q[s] <= x2_q[s-1];
      end
    end
    for (int l = 0; l < N_LANES; l++) begin
      if (en[0]) begin
        prod_q[l] <= term_in[l] * in_chain_i.x2;
        sum0_q[l] <= sum_in[l];
      end
      if (en[1]) begin
        u1_q[l]   <= u_d[l];
        sum1_q[l] <= sum0_q[l];
      end
      if (en[2]) begin
        u2_q[l]   <= u1_q[l];
        est_q[l]  <= m[l][2*U_W-1:U_W];
        sum2_q[l] <= sum1_q[l];
      end
      if (en[3]) begin
        t3_q[l]   <= fix[l][T_W-1:0];
        sum3_q[l] <= sum2_q[l];
      end
      if (en[4]) begin
        t4_q[l]   <= t3_q[l];
        sum4_q[l] <= sum3_q[l] + S_W'(t3_q[l]);
      end
    end
  end

  always_comb begin
    out_chain_o.sin_term = t4_q[LANE_SIN];
    out_chain_o.cos_term = t4_q[LANE_COS];
    out_chain_o.sin_sum  = sum4_q[LANE_SIN];
    out_chain_o.cos_sum  = sum4_q[LANE_COS];
    out_chain_o.x2       = x2_q[CELL_STAGES-1];
  end

  assign out_valid_o = v_q[CELL_STAGES-1];

endmodule

### design/sine_cosine_taylor_unit.sv
// Fixed-point sine and cosine by Taylor series.
//
// Each request on angle_i carries one angle in radians (signed, FRAC_BITS
// fraction bits). The angle is reduced to about -pi..pi by a multiply with
// 1/(2pi), then a row of four identical cells adds one sine term and one
// cosine term each. Every result on result_o holds the saturated sine and
// cosine (signed, FRAC_BITS fraction bits), one result per request, in order.
//
// From acceptance to result valid, a request passes five reduction
// stages, five stages in each of the four cells and the output register.
// One request is accepted per cycle while the receiver takes results; the
// multipliers in each stage set that figure, each used once per request.
//
// Reset clears every valid bit; the pipeline is empty afterwards. When the
// receiver stalls, the result waits in the output register and requests are
// still taken until every stage ahead of the output holds an item; only then
// does angle_i.ready drop.
module sine_cosine_taylor_unit import sct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sct_angle_if.sink    angle_i,
  sct_result_if.source result_o
);

  chain_t            link_chain [N_CELLS+1];
  logic [N_CELLS:0]  link_valid;
  logic [N_CELLS:0]  link_ready;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] sine_q;
  logic signed [OUT_W-1:0] cosine_q;
  logic                    out_en;

  // Angle reduction and squaring.
  sct_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (angle_i.valid),
    .in_ready_o  (angle_i.ready),
    .in_angle_i  (angle_i.angle),
    .out_valid_o (link_valid[0]),
    .out_ready_i (link_ready[0]),
    .out_chain_o (link_chain[0])
  );

  // Row of term cells.
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    sct_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (CELL_W'(g)),
      .in_valid_i  (link_valid[g]),
      .in_ready_o  (link_ready[g]),
      .in_chain_i  (link_chain[g]),
      .out_valid_o (link_valid[g+1]),
      .out_ready_i (link_ready[g+1]),
      .out_chain_o (link_chain[g+1])
    );
  end

  // Output register with saturation.
  assign out_en              = !out_valid_q || result_o.ready;
  assign link_ready[N_CELLS] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= link_valid[N_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      sine_q   <= sat_out(link_chain[N_CELLS].sin_sum);
      cosine_q <= sat_out(link_chain[N_CELLS].cos_sum);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.sine_value   = sine_q;
  assign result_o.cosine_value = cosine_q;

endmodule

### design/sct_checker.sv
module sct_checker import sct_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] sine_value_i,
  input logic signed [OUT_W-1:0] cosine_value_i
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Requests accepted but not yet delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result keeps its value.
  a_stall_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sine_value_i) && $stable(cosine_value_i))
    else $error("result changed while stalled");

  // A result stays offered until taken.
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before taken");

  // No result without an outstanding request.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != '0)
    else $error("result without a request");

  // The pipeline never holds more requests than it has stages.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  // A ready receiver lets the whole pipeline advance.
  a_ready_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while receiver ready");

endmodule

bind sine_cosine_taylor_unit sct_checker u_sct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (angle_i.valid),
  .in_ready_i     (angle_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .sine_value_i   (result_o.sine_value),
  .cosine_value_i (result_o.cosine_value)
);

### bench/sct_sincos_checker.sv
module sct_sincos_checker import sct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sct_angle_if  angle_mon,
  sct_result_if result_mon,
  output int    fail_count_o,
  output int    pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // One expected sine and cosine pair.
  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } sincos_t;

  localparam longint ONE = 64'sd1;
  localparam longint SIN_K [4] = '{6, 20, 42, 72};
  localparam longint COS_K [4] = '{2, 12, 30, 56};

  sincos_t expected_sincos [$];
  int      mismatches;

  // Division that rounds toward minus infinity.
  function automatic longint div_floor(input longint v, input longint d);
    if (v >= 0) begin
      return v / d;
    end
    return -((-(v + 1)) / d) - 1;
  endfunction

  // Saturate a series sum to the result width.
  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    longint w;
    w = v;
    if (w > OUT_MAX) begin
      w = OUT_MAX;
    end else if (w < OUT_MIN) begin
      w = OUT_MIN;
    end
    return OUT_W'(w);
  endfunction

  // Range reduction followed by the truncated Taylor series for both lanes.
  function automatic sincos_t taylor_sincos(input logic signed [ANGLE_W-1:0] ang);
    longint  a;
    longint  turns;
    longint  r40;
    longint  r;
    longint  x2;
    longint  term;
    longint  s_acc;
    longint  c_acc;
    int      i;
    sincos_t res;
    a = longint'(ang);
    // Nearest whole turn, ties rounded up, then subtract it at 40 fraction bits.
    turns = (a * longint'(INV_TWO_PI) + (ONE <<< (FRAC_BITS + 31))) >>> (FRAC_BITS + 32);
    r40 = a * (ONE <<< (TWO_PI_FRAC - FRAC_BITS)) - turns * longint'(TWO_PI);
    r = r40 >>> (TWO_PI_FRAC - FRAC_BITS);
    x2 = (r * r) >>> FRAC_BITS;
    // Sine: odd terms, each the previous one times -x^2/k.
    term = r;
    s_acc = r;
    for (i = 0; i < 4; i++) begin
      term = div_floor(-(term * x2), SIN_K[i] * (ONE <<< FRAC_BITS));
      s_acc += term;
    end
    // Cosine: even terms starting from one.
    term = ONE <<< FRAC_BITS;
    c_acc = term;
    for (i = 0; i < 4; i++) begin
      term = div_floor(-(term * x2), COS_K[i] * (ONE <<< FRAC_BITS));
      c_acc += term;
    end
    res.sine = clamp_out(s_acc);
    res.cosine = clamp_out(c_acc);
    return res;
  endfunction

  // Record each accepted request and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    sincos_t want;
    if (!rst_ni) begin
      expected_sincos.delete();
      mismatches = 0;
    end else begin
      if (angle_mon.valid && angle_mon.ready) begin
        expected_sincos.push_back(taylor_sincos(angle_mon.angle));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_sincos.size() == 0) begin
          $error("result with no request outstanding: sine_value %0d cosine_value %0d",
                 result_mon.sine_value, result_mon.cosine_value);
          mismatches++;
        end else begin
          want = expected_sincos.pop_front();
          if (result_mon.sine_value !== want.sine) begin
            $error("sine_value: expected %0d, actual %0d", want.sine, result_mon.sine_value);
            mismatches++;
          end
          if (result_mon.cosine_value !== want.cosine) begin
            $error("cosine_value: expected %0d, actual %0d",
                   want.cosine, result_mon.cosine_value);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= expected_sincos.size();
  end

endmodule

### bench/tb_sine_cosine_taylor_unit.sv
module tb_sine_cosine_taylor_unit import sct_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_REQUESTS = 1300;
  localparam int     IDLE_LIMIT      = 2000;
  localparam longint PI_Q            = 205887;
  localparam longint HALF_PI_Q       = 102944;
  localparam longint TWO_PI_Q        = 411775;

  // Receiver behavior, chosen anew at random when the current mode's run ends.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY_READY,
    RX_MOSTLY_STALLED,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   burst_left;

  rx_mode_e rx_mode;
  int       rx_left;

  sct_angle_if  angle_if ();
  sct_result_if result_if ();

  sine_cosine_taylor_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .angle_i  (angle_if),
    .result_o (result_if)
  );

  sct_sincos_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .angle_mon    (angle_if),
    .result_mon   (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 96);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN: begin
          result_if.ready <= 1'b1;
        end
        RX_MOSTLY_READY: begin
          result_if.ready <= ($urandom_range(0, 3) != 0);
        end
        RX_MOSTLY_STALLED: begin
          result_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_if.ready <= (rx_left % 8 == 0);
        end
      endcase
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((angle_if.valid && angle_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one angle request and hold it until taken; gaps follow a burst.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] value);
    angle_if.valid <= 1'b1;
    angle_if.angle <= value;
    do begin
      @(posedge clk_i);
    end while (!angle_if.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      angle_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  initial begin
    longint wide;
    int     i;
    angle_if.valid = 1'b0;
    angle_if.angle = '0;
    result_if.ready = 1'b0;
    rst_ni = 1'b0;
    idle_cycles = 0;
    burst_left = 8;
    rx_mode = RX_OPEN;
    rx_left = 40;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed angles: field extremes, quarter and half turns, and the
    // reduction edges around plus and minus pi.
    send_angle(32'sd0);
    send_angle(32'sd1);
    send_angle(-32'sd1);
    send_angle(32'sh7FFFFFFF);
    send_angle(32'sh80000000);
    send_angle(32'sh00010000);
    send_angle(-32'sh00010000);
    send_angle(32'(HALF_PI_Q));
    send_angle(32'(-HALF_PI_Q));
    send_angle(32'(PI_Q));
    send_angle(32'(PI_Q - 1));
    send_angle(32'(PI_Q + 1));
    send_angle(32'(-PI_Q));
    send_angle(32'(-PI_Q - 1));
    send_angle(32'(-PI_Q + 1));
    send_angle(32'(TWO_PI_Q));
    send_angle(32'(TWO_PI_Q - 1));
    send_angle(32'(TWO_PI_Q + 1));
    send_angle(32'(3 * PI_Q));
    send_angle(32'(100 * TWO_PI_Q + PI_Q));
    send_angle(32'(-5000 * TWO_PI_Q - PI_Q));
    send_angle(32'sh55555555);
    send_angle(32'shAAAAAAAA);

    // Random angles: within two turns either way, within about twenty turns,
    // half-turn edges at up to 5000 turns either way, and the full input range.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          wide = longint'($urandom_range(0, 4 * TWO_PI_Q)) - 2 * TWO_PI_Q;
        end
        2: begin
          wide = (longint'($urandom_range(0, 10000)) - 5000) * TWO_PI_Q
                 + (($urandom_range(0, 1) == 1) ? PI_Q : -PI_Q)
                 + longint'($urandom_range(0, 16)) - 8;
        end
        3: begin
          wide = longint'($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        end
        default: begin
          wide = longint'($urandom());
        end
      endcase
      send_angle(32'(wide));
    end
    angle_if.valid <= 1'b0;

    // Drain the pipeline, then give late results time to show up.
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/sct_pkg.sv
design/sct_channels_if.sv
design/sct_reduce.sv
design/sct_cell.sv
design/sine_cosine_taylor_unit.sv
design/sct_checker.sv
bench/sct_sincos_checker.sv
bench/tb_sine_cosine_taylor_unit.sv
